// ===== sv/bda_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and helpers for the binary to decimal ASCII converter.
package bda_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int IN_VALUE_W      = 64;
    localparam int CHAR_W          = 8;
    localparam int RADIX           = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // decimal digits of 2^w - 1: floor(w * log10(2)) + 1, log10(2) ~ 1233 / 4096
    function automatic int num_digits(input int w);
        int n;
        n = ((w * 1233) >> 12) + 1;
        if (RADIX != 10) begin
            n = w;
        end
        return n;
    endfunction

endpackage

// ===== sv/bda_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the converter input and output words.
interface bda_in_if;
    import bda_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [IN_VALUE_W-1:0] value;
    logic                  is_signed;

    modport source (output valid, output value, output is_signed, input ready);
    modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface bda_out_if;
    import bda_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== sv/binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// Binary to decimal ASCII converter: microcoded double-dabble sequencer and output register.
//
// Converts the low VALUE_WIDTH bits of each input word (two's complement when
// is_signed is set) to decimal text, one ASCII character per output word, most
// significant digit first, '-' ahead of a negative value, last set on the final
// digit. The sequencer accepts the word, runs one shift-and-add-3 step per input
// bit, strips leading zero digits from the BCD register one at a time, sends the
// '-' for a negative value from its sign step, then sends one character per digit
// as the output register frees up. A new word is taken while the final character
// still waits in the output register.
module binary_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bda_in_if.sink    i_in,
    bda_out_if.source o_out
);
    import bda_pkg::*;

    localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BITS_W     = $clog2(VALUE_WIDTH + 1);
    localparam int REMAIN_W   = $clog2(NUM_DIGITS + 1);
    localparam int PC_W       = 3;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_DABBLE,
        OP_NORM,
        OP_SIGN,
        OP_EMIT,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        C_NO_ACCEPT,
        C_BITS_LEFT,
        C_LEAD_ZERO,
        C_SIGN_WAIT,
        C_EMIT_WAIT,
        C_ALWAYS
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    localparam t_pc STEP_WAIT   = 3'd0;
    localparam t_pc STEP_DABBLE = 3'd1;
    localparam t_pc STEP_NORM   = 3'd2;
    localparam t_pc STEP_SIGN   = 3'd3;
    localparam t_pc STEP_EMIT   = 3'd4;
    localparam t_pc STEP_DONE   = 3'd5;

    t_pc                   r_pc, n_pc;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [BITS_W-1:0]     r_bits, n_bits;
    logic [REMAIN_W-1:0]   r_remain, n_remain;
    logic                  r_neg, n_neg;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    t_ctrl                  ctrl;
    logic                   in_accept;
    logic                   out_free;
    logic                   lead_zero;
    logic                   remain_one;
    logic                   cond_hit;
    logic [VALUE_WIDTH-1:0] in_v;
    logic                   in_neg;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;

    // microprogram
    always_comb begin
        unique case (r_pc)
            STEP_WAIT:   ctrl = '{op: OP_WAIT,   cond: C_NO_ACCEPT, target: STEP_WAIT};
            STEP_DABBLE: ctrl = '{op: OP_DABBLE, cond: C_BITS_LEFT, target: STEP_DABBLE};
            STEP_NORM:   ctrl = '{op: OP_NORM,   cond: C_LEAD_ZERO, target: STEP_NORM};
            STEP_SIGN:   ctrl = '{op: OP_SIGN,   cond: C_SIGN_WAIT, target: STEP_SIGN};
            STEP_EMIT:   ctrl = '{op: OP_EMIT,   cond: C_EMIT_WAIT, target: STEP_EMIT};
            default:     ctrl = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_WAIT};
        endcase
    end

    assign i_in.ready      = (ctrl.op == OP_WAIT);
    assign in_accept       = i_in.valid && i_in.ready;
    assign out_free        = !r_out_valid || o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;

    assign in_v       = i_in.value[VALUE_WIDTH-1:0];
    assign in_neg     = i_in.is_signed && in_v[VALUE_WIDTH-1];
    assign top_digit  = r_bcd[BCD_W-1 -: 4];
    assign remain_one = (r_remain == REMAIN_W'(1));
    assign lead_zero  = (top_digit == 4'd0) && !remain_one;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        unique case (ctrl.cond)
            C_NO_ACCEPT: cond_hit = !in_accept;
            C_BITS_LEFT: cond_hit = (r_bits != BITS_W'(1));
            C_LEAD_ZERO: cond_hit = lead_zero;
            C_SIGN_WAIT: cond_hit = r_neg && !out_free;
            C_EMIT_WAIT: cond_hit = !(out_free && remain_one);
            default:     cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        n_pc        = cond_hit ? ctrl.target : r_pc + t_pc'(1);
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_bits      = r_bits;
        n_remain    = r_remain;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;

        unique case (ctrl.op)
            OP_WAIT: begin
                if (in_accept) begin
                    n_bin    = in_neg ? ({VALUE_WIDTH{1'b0}} - in_v) : in_v;
                    n_neg    = in_neg;
                    n_bcd    = '0;
                    n_bits   = BITS_W'(VALUE_WIDTH);
                    n_remain = REMAIN_W'(NUM_DIGITS);
                end
            end
            OP_DABBLE: begin
                n_bcd  = {bcd_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin  = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_bits = r_bits - BITS_W'(1);
            end
            OP_NORM: begin
                if (lead_zero) begin
                    n_bcd    = {r_bcd[BCD_W-5:0], 4'd0};
                    n_remain = r_remain - REMAIN_W'(1);
                end
            end
            OP_SIGN: begin
                if (r_neg && out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_ZERO + {4'd0, top_digit};
                    n_last      = remain_one;
                    n_bcd       = {r_bcd[BCD_W-5:0], 4'd0};
                    n_remain    = r_remain - REMAIN_W'(1);
                end
            end
            default: begin
                n_bin = r_bin;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_bits   <= n_bits;
        r_remain <= n_remain;
        r_neg    <= n_neg;
        r_char   <= n_char;
        r_last   <= n_last;
    end

endmodule

// ===== verif/decimal_text_check.sv =====
`timescale 1ns / 1ps
// Converter checker: predicts the decimal text of each input word and compares the output.
module decimal_text_check #(
    parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [bda_pkg::IN_VALUE_W-1:0] i_value,
    input  logic                           i_is_signed,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [bda_pkg::CHAR_W-1:0]     i_char_code,
    input  logic                           i_last,
    output int                             o_mismatches,
    output int                             o_pending
);
    import bda_pkg::*;

    localparam int MAX_DIGITS = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_text_word;

    t_text_word expected_text [$];
    int         mismatch_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = expected_text.size();

    function automatic void predict_text(input logic [IN_VALUE_W-1:0] raw, input logic sgn);
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digit [MAX_DIGITS];
        logic                   neg;
        int                     n;
        mag = raw[VALUE_WIDTH-1:0];
        neg = sgn & mag[VALUE_WIDTH-1];
        if (neg) begin
            mag = -mag;
        end
        n = 0;
        do begin
            digit[n] = 4'(mag % RADIX);
            mag      = mag / RADIX;
            n++;
        end while (mag != 0);
        if (neg) begin
            expected_text.push_back('{CHAR_MINUS, 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            expected_text.push_back('{CHAR_ZERO + 8'(digit[i]), i == 0});
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_word want;
        if (!i_rst_n) begin
            expected_text.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_text.size() == 0) begin
                    $error("char_code: no word expected, got %0d", i_char_code);
                    mismatch_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_char_code !== want.char_code) begin
                        $error("char_code: expected %0d, got %0d", want.char_code, i_char_code);
                        mismatch_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_last);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_text(i_value, i_is_signed);
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Converter testbench top: clock, reset, number stimulus, output back-pressure and verdict.
module testbench;
    import bda_pkg::*;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_NUMBERS   = 280;
    localparam int DRAIN_CYCLES     = 120;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    bit   steady       = 1'b0;
    bit   hold_request = 1'b0;

    bda_in_if  in_ch ();
    bda_out_if out_ch ();

    binary_to_decimal_ascii_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    decimal_text_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_value      (in_ch.value),
        .i_is_signed  (in_ch.is_signed),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_char_code  (out_ch.char_code),
        .i_last       (out_ch.last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_cycles();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_VALUE_W-1:0] random_number();
        logic [IN_VALUE_W-1:0] v;
        logic [IN_VALUE_W-1:0] p;
        logic [IN_VALUE_W-1:0] near;
        v    = {$urandom, $urandom};
        near = IN_VALUE_W'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            1: begin
                v = v >> $urandom_range(1, 63);
            end
            2: begin
                v = -(v >> $urandom_range(1, 63));
            end
            3: begin
                p = 1;
                repeat ($urandom_range(1, 19)) p = p * RADIX;
                v = p - 1 + IN_VALUE_W'($urandom_range(0, 2));
            end
            4: begin
                v = $urandom_range(0, 1) ? ({1'b1, {(IN_VALUE_W-1){1'b0}}} | near) : ~near;
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    task automatic send_number(input logic [IN_VALUE_W-1:0] v, input logic s);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.value     <= v;
        in_ch.is_signed <= s;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    initial begin
        logic [IN_VALUE_W:0] directed [] = '{
            {1'b0, 64'd0},
            {1'b1, 64'd0},
            {1'b0, 64'd1},
            {1'b0, 64'd9},
            {1'b0, 64'd10},
            {1'b1, 64'd99},
            {1'b0, 64'd100},
            {1'b1, 64'd12345},
            {1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
            {1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
            {1'b1, 64'h8000_0000_0000_0000},
            {1'b0, 64'h8000_0000_0000_0000},
            {1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
            {1'b0, 64'h7FFF_FFFF_FFFF_FFFF},
            {1'b0, 64'h8AC7_2304_89E8_0000},
            {1'b0, 64'h8AC7_2304_89E7_FFFF},
            {1'b1, 64'hFFFF_FFFF_FFFF_FFF6},
            {1'b1, 64'h5555_5555_5555_5555},
            {1'b0, 64'hAAAA_AAAA_AAAA_AAAA},
            {1'b1, 64'hAAAA_AAAA_AAAA_AAAA}
        };
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.value     <= '0;
        in_ch.is_signed <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_number(directed[i][IN_VALUE_W-1:0], directed[i][IN_VALUE_W]);
        end

        for (int i = 0; i < RANDOM_NUMBERS; i++) begin
            if (i % 40 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            // stall the output long enough to back up the input
            if (i == 20 || i == 150) begin
                hold_request = 1'b1;
            end
            send_number(random_number(), 1'($urandom_range(0, 1)));
        end
        in_ch.valid <= 1'b0;
        steady = 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
            stall = idle_cycles();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
